>>> hw/rtl/srl_pkg.sv
package srl_pkg;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic REG_LOCK_MODE     = 1'b0;
   localparam logic REG_INITIAL_COUNT = 1'b1;

   // Field widths
   localparam int unsigned TASK_W   = 8;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned DEPTH_W  = 8;
   localparam int unsigned STATUS_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd1;

   // Request actions
   localparam logic ACT_WAIT   = 1'b0;
   localparam logic ACT_SIGNAL = 1'b1;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED    = 3'd0,
      ST_BLOCKED    = 3'd1,
      ST_RELEASED   = 3'd2,
      ST_ALREADY    = 3'd3,
      ST_NOT_HOLDER = 3'd4,
      ST_OVERFLOW   = 3'd5
   } status_type;

   // Control broadcast to every cell of the wait queue
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } queue_ctrl_type;

endpackage

>>> hw/rtl/semaphore_recursive_lock_unit_core.sv
// Hardware semaphore with a FIFO of waiting tasks and an optional recursive
// lock mode (holder plus recursion depth). Each request on req_ carries an
// action and a task ID and produces exactly one response on rsp_ in the cycle
// after it is accepted. The count, holder and wait-queue cells update as it is
// accepted, so a new request is taken every cycle while the response side
// keeps up; the output register lets the next request enter in the same cycle
// as the previous response is taken. Waiting tasks sit in a row of WAIT_DEPTH
// cells; each cell compares its task's slot against the request's, so the
// "already waiting" check needs no per-task flag table. A word-aligned
// configuration write reloads the count and empties the queue and the holder.
module semaphore_recursive_lock_unit_core #(
   parameter int unsigned WAIT_DEPTH = 16,
   parameter int unsigned MAX_TASKS  = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // action[0], task_id[8:1], zero pad
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // status[2:0], wake_valid[3],
                                                         // wake_task[11:4], count_now[19:12]
   // Register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [srl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [srl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [srl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned SLOT_W = (MAX_TASKS >= 256) ? 8 : $clog2(MAX_TASKS);

   // Task to flag-slot map (task_id modulo MAX_TASKS)
   logic [SLOT_W-1:0] slot_lut [256];
   genvar g;
   generate
      for (g = 0; g < 256; g++) begin : g_lut
         assign slot_lut[g] = SLOT_W'(g % MAX_TASKS);
      end
   endgenerate

   // Configuration and state registers
   logic                          lock_mode_ff, lock_mode_in;
   logic [srl_pkg::COUNT_W-1:0]   init_count_ff, init_count_in;
   logic [srl_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          holder_valid_ff, holder_valid_in;
   logic [srl_pkg::TASK_W-1:0]    holder_task_ff, holder_task_in;
   logic [srl_pkg::DEPTH_W-1:0]   depth_ff, depth_in;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   srl_pkg::status_type           status_ff, status_in;
   logic                          wake_valid_ff, wake_valid_in;
   logic [srl_pkg::TASK_W-1:0]    wake_task_ff, wake_task_in;
   logic [srl_pkg::COUNT_W-1:0]   count_now_ff;

   // Request fields
   logic                          req_action;
   logic [srl_pkg::TASK_W-1:0]    req_task;
   logic [SLOT_W-1:0]             req_slot;
   logic                          req_accept;

   // Queue interface
   srl_pkg::queue_ctrl_type       q_ctrl;
   logic                          q_head_valid;
   logic [srl_pkg::TASK_W-1:0]    q_head_task;
   logic                          q_full;
   logic                          q_hit;

   // Helpers
   logic                          cfg_write;
   logic                          cfg_index;
   logic                          cfg_hit;
   logic                          holder_match;
   srl_pkg::status_type           wait_status;
   logic [srl_pkg::COUNT_W-1:0]   count_inc;

   assign req_action = req_tdata[0];
   assign req_task   = req_tdata[8:1];
   assign req_slot   = slot_lut[req_task];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = csr_paddr[2];
   assign cfg_hit    = cfg_write && (csr_paddr[1:0] == 2'b00);

   // Register read-back
   always_comb begin
      csr_prdata = '0;
      case (cfg_index)
         srl_pkg::REG_LOCK_MODE:     csr_prdata[0] = lock_mode_ff;
         srl_pkg::REG_INITIAL_COUNT: csr_prdata[srl_pkg::COUNT_W-1:0] = init_count_ff;
         default:                    csr_prdata = '0;
      endcase
   end

   // Outcome of a plain semaphore wait
   always_comb begin
      if (count_ff != '0) begin
         wait_status = srl_pkg::ST_GRANTED;
      end else if (q_hit) begin
         wait_status = srl_pkg::ST_ALREADY;
      end else if (q_full) begin
         wait_status = srl_pkg::ST_OVERFLOW;
      end else begin
         wait_status = srl_pkg::ST_BLOCKED;
      end
   end

   assign holder_match = holder_valid_ff && (holder_task_ff == req_task);
   assign count_inc    = (count_ff == srl_pkg::COUNT_MAX) ? count_ff
                                                          : count_ff + 8'd1;

   // Request processing and configuration reload
   always_comb begin
      lock_mode_in    = lock_mode_ff;
      init_count_in   = init_count_ff;
      count_in        = count_ff;
      holder_valid_in = holder_valid_ff;
      holder_task_in  = holder_task_ff;
      depth_in        = depth_ff;
      q_ctrl          = '0;
      status_in       = srl_pkg::ST_GRANTED;
      wake_valid_in   = 1'b0;
      wake_task_in    = '0;

      if (cfg_hit) begin
         if (cfg_index == srl_pkg::REG_LOCK_MODE) begin
            lock_mode_in = csr_pwdata[0];
         end else begin
            init_count_in = csr_pwdata[srl_pkg::COUNT_W-1:0];
         end
         count_in        = lock_mode_in ? srl_pkg::COUNT_RESET : init_count_in;
         holder_valid_in = 1'b0;
         holder_task_in  = '0;
         depth_in        = '0;
         q_ctrl.clear    = 1'b1;
      end else if (req_accept) begin
         if (req_action == srl_pkg::ACT_WAIT) begin
            if (lock_mode_ff && holder_match) begin
               // Re-acquire by the holder
               if (depth_ff == srl_pkg::DEPTH_MAX) begin
                  status_in = srl_pkg::ST_OVERFLOW;
               end else begin
                  depth_in  = depth_ff + 8'd1;
                  status_in = srl_pkg::ST_GRANTED;
               end
            end else begin
               status_in = wait_status;
               case (wait_status)
                  srl_pkg::ST_GRANTED: begin
                     count_in = count_ff - 8'd1;
                     if (lock_mode_ff) begin
                        holder_valid_in = 1'b1;
                        holder_task_in  = req_task;
                        depth_in        = 8'd1;
                     end
                  end
                  srl_pkg::ST_BLOCKED: q_ctrl.push = 1'b1;
                  default: ;
               endcase
            end
         end else begin
            if (lock_mode_ff && !holder_match) begin
               status_in = srl_pkg::ST_NOT_HOLDER;
            end else if (lock_mode_ff && (depth_ff > 8'd1)) begin
               depth_in  = depth_ff - 8'd1;
               status_in = srl_pkg::ST_RELEASED;
            end else begin
               // Final release or plain signal: wake the oldest waiter
               if (lock_mode_ff) begin
                  holder_valid_in = 1'b0;
                  holder_task_in  = '0;
                  depth_in        = '0;
               end
               status_in = srl_pkg::ST_RELEASED;
               count_in  = count_inc;
               if (q_head_valid) begin
                  q_ctrl.pop    = 1'b1;
                  wake_valid_in = 1'b1;
                  wake_task_in  = q_head_task;
               end
            end
         end
      end
   end

   // Response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_mode_ff    <= 1'b0;
         init_count_ff   <= srl_pkg::COUNT_RESET;
         count_ff        <= srl_pkg::COUNT_RESET;
         holder_valid_ff <= 1'b0;
         holder_task_ff  <= '0;
         depth_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         lock_mode_ff    <= lock_mode_in;
         init_count_ff   <= init_count_in;
         count_ff        <= count_in;
         holder_valid_ff <= holder_valid_in;
         holder_task_ff  <= holder_task_in;
         depth_ff        <= depth_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff     <= status_in;
         wake_valid_ff <= wake_valid_in;
         wake_task_ff  <= wake_task_in;
         count_now_ff  <= count_in;
      end
   end

   srl_queue #(
      .WAIT_DEPTH (WAIT_DEPTH),
      .SLOT_W     (SLOT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (q_ctrl),
      .push_task  (req_task),
      .push_slot  (req_slot),
      .req_slot   (req_slot),
      .head_valid (q_head_valid),
      .head_task  (q_head_task),
      .full       (q_full),
      .hit        (q_hit)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, count_now_ff, wake_task_ff, wake_valid_ff, status_ff};

   // Holder and depth move together
   a_holder_depth: assert property (@(posedge clock) disable iff (reset)
      holder_valid_ff == (depth_ff != '0))
      else $error("holder valid and recursion depth disagree");

   // In lock mode the count is 1 exactly when nobody holds the lock
   a_lock_count: assert property (@(posedge clock) disable iff (reset)
      lock_mode_ff |-> (count_ff == {7'b0, !holder_valid_ff}))
      else $error("lock mode count out of step with holder");

   // Every accepted request leaves a response pending
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // A blocked request leaves a waiter in the queue
   a_blocked_queued: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !cfg_hit && (status_in == srl_pkg::ST_BLOCKED)) |=> q_head_valid)
      else $error("blocked request left the queue empty");

endmodule

>>> hw/rtl/srl_cell.sv
// One slot of the wait queue. Shifts toward the head on pop, captures the
// pushed task when it is the first empty slot behind a full one.
module srl_cell #(
   parameter int unsigned SLOT_W = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  srl_pkg::queue_ctrl_type        ctrl,
   input  logic                           prev_valid,
   input  logic                           next_valid,
   input  logic [srl_pkg::TASK_W-1:0]     next_task,
   input  logic [SLOT_W-1:0]              next_slot,
   input  logic [srl_pkg::TASK_W-1:0]     push_task,
   input  logic [SLOT_W-1:0]              push_slot,
   input  logic [SLOT_W-1:0]              req_slot,
   output logic                           valid,
   output logic [srl_pkg::TASK_W-1:0]     task_id,
   output logic [SLOT_W-1:0]              slot,
   output logic                           hit
);

   logic                       valid_ff, valid_in;
   logic [srl_pkg::TASK_W-1:0] task_ff, task_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic                       load_push;

   assign load_push = ctrl.push && prev_valid && !valid_ff;

   // Next content of the slot
   always_comb begin
      valid_in = valid_ff;
      task_in  = task_ff;
      slot_in  = slot_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.pop) begin
         valid_in = next_valid;
         task_in  = next_task;
         slot_in  = next_slot;
      end else if (load_push) begin
         valid_in = 1'b1;
         task_in  = push_task;
         slot_in  = push_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      task_ff <= task_in;
      slot_ff <= slot_in;
   end

   assign valid   = valid_ff;
   assign task_id = task_ff;
   assign slot    = slot_ff;
   assign hit     = valid_ff && (slot_ff == req_slot);

endmodule

>>> hw/rtl/srl_queue.sv
// Wait queue built as a row of cells; cell 0 is the oldest waiter.
module srl_queue #(
   parameter int unsigned WAIT_DEPTH = 16,
   parameter int unsigned SLOT_W     = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  srl_pkg::queue_ctrl_type        ctrl,
   input  logic [srl_pkg::TASK_W-1:0]     push_task,
   input  logic [SLOT_W-1:0]              push_slot,
   input  logic [SLOT_W-1:0]              req_slot,
   output logic                           head_valid,
   output logic [srl_pkg::TASK_W-1:0]     head_task,
   output logic                           full,
   output logic                           hit
);

   logic                       cell_valid [WAIT_DEPTH];
   logic [srl_pkg::TASK_W-1:0] cell_task  [WAIT_DEPTH];
   logic [SLOT_W-1:0]          cell_slot  [WAIT_DEPTH];
   logic [WAIT_DEPTH-1:0]      cell_hit;

   genvar g;
   generate
      for (g = 0; g < WAIT_DEPTH; g++) begin : g_cell
         logic                       prev_v;
         logic                       nxt_v;
         logic [srl_pkg::TASK_W-1:0] nxt_t;
         logic [SLOT_W-1:0]          nxt_s;

         // Neighbor links: head sees a full slot before it, tail sees empty after
         if (g == 0) begin : g_head
            assign prev_v = 1'b1;
         end else begin : g_mid
            assign prev_v = cell_valid[g-1];
         end
         if (g == WAIT_DEPTH - 1) begin : g_tail
            assign nxt_v = 1'b0;
            assign nxt_t = '0;
            assign nxt_s = '0;
         end else begin : g_body
            assign nxt_v = cell_valid[g+1];
            assign nxt_t = cell_task[g+1];
            assign nxt_s = cell_slot[g+1];
         end

         srl_cell #(
            .SLOT_W (SLOT_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .next_valid (nxt_v),
            .next_task  (nxt_t),
            .next_slot  (nxt_s),
            .push_task  (push_task),
            .push_slot  (push_slot),
            .req_slot   (req_slot),
            .valid      (cell_valid[g]),
            .task_id    (cell_task[g]),
            .slot       (cell_slot[g]),
            .hit        (cell_hit[g])
         );
      end
   endgenerate

   assign head_valid = cell_valid[0];
   assign head_task  = cell_task[0];
   assign full       = cell_valid[WAIT_DEPTH-1];
   assign hit        = |cell_hit;

endmodule
